// File: rtl/p2phc_pkg.sv
// ----------------------------------------------------------------------------
// p2phc_pkg
// Types and constants shared by the message header checker files.
// ----------------------------------------------------------------------------
package p2phc_pkg;

  localparam int unsigned CMD_LEN = 12;
  localparam int unsigned NUM_NAMES = 3;

  localparam logic [4:0] HDR_LEN    = 5'd24;
  localparam logic [4:0] CMD_FIRST  = 5'd4;
  localparam logic [4:0] SIZE_FIRST = 5'd16;
  localparam logic [4:0] SIZE_END   = 5'd20;
  localparam logic [4:0] LAST_BYTE  = 5'd23;

  localparam logic [31:0] SIZE_LIMIT_ABS = 32'h7fff_ffff;
  localparam logic [7:0]  PRINT_MIN      = 8'h20;
  localparam logic [7:0]  PRINT_MAX      = 8'h7e;

  localparam logic [31:0] MAGIC_RST   = 32'he8f3_e1e3;
  localparam logic [31:0] MAX_PAY_RST = 32'h0020_0000;

  // block, cmpctblock, blocktxn, zero padded
  localparam logic [7:0] BLK_NAMES [NUM_NAMES][CMD_LEN] = '{
    '{8'h62, 8'h6c, 8'h6f, 8'h63, 8'h6b, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h63, 8'h6d, 8'h70, 8'h63, 8'h74, 8'h62,
      8'h6c, 8'h6f, 8'h63, 8'h6b, 8'h00, 8'h00},
    '{8'h62, 8'h6c, 8'h6f, 8'h63, 8'h6b, 8'h74,
      8'h78, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] BLK_LENS [NUM_NAMES] = '{4'd5, 4'd10, 4'd8};

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_MAGIC = 2'd1,
    ERR_CMD   = 2'd2,
    ERR_SIZE  = 2'd3
  } err_e;

  typedef enum logic {
    REG_MAGIC   = 1'b0,
    REG_MAX_PAY = 1'b1
  } reg_e;

endpackage

// File: rtl/p2phc_if.sv
// ----------------------------------------------------------------------------
// p2phc_if
// Valid/ready channels for header bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface p2phc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hdr_byte;
  logic       start_req;

  modport source (output valid, output hdr_byte, output start_req, input ready);
  modport sink   (input valid, input hdr_byte, input start_req, output ready);
endinterface

interface p2phc_out_if;
  logic        valid;
  logic        ready;
  logic        header_ok;
  logic [1:0]  error_code;
  logic [31:0] payload_size;
  logic        is_block_like;

  modport source (output valid, output header_ok, output error_code,
                  output payload_size, output is_block_like, input ready);
  modport sink   (input valid, input header_ok, input error_code,
                  input payload_size, input is_block_like, output ready);
endinterface

// File: rtl/p2p_message_header_checker.sv
// ----------------------------------------------------------------------------
// p2p_message_header_checker
// Checks a 24-byte message header (magic, command, size, checksum) one byte
// per item and gives one verdict on the last byte.
// ----------------------------------------------------------------------------
// Takes one header byte per cycle unless a held verdict is stalled. Each
// byte lands in an input register, is checked by one level of compare logic
// against the running header state, and the verdict of the 24th byte is held
// in a result register, so a verdict passes through both registers in turn.
// The input side keeps accepting while a verdict waits, until that
// verdict and one more byte are both held. start_req restarts a header at
// any time; after a verdict, bytes without start_req are dropped. Registers:
// 0x0 magic word (first wire byte in bits 7:0), 0x4 max payload size.
module p2p_message_header_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  p2phc_in_if.sink           hdr_i,
  p2phc_out_if.source        res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import p2phc_pkg::*;

  logic [31:0] magic_q, max_pay_q;
  reg_e        reg_sel;
  logic        cfg_we;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  byte_q;
  logic        start_q;
  logic        in_acc, advance;

  logic [4:0]  pos_q, pos_d;
  logic        magic_ok_q, magic_ok_d;
  logic        zero_q, zero_d;
  logic        cmd_ok_q, cmd_ok_d;
  logic [2:0]  name_q, name_d;
  logic [31:0] size_q, size_d;

  logic        out_valid_q, out_valid_d;
  logic        emit;
  err_e        err_d, err_q;
  logic        blk_d, blk_q;
  logic        ok_q;
  logic [31:0] size_out_q;
  logic [3:0]  cidx;

  // config port
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign cfg_we  = psel & penable & pwrite;

  always_comb begin
    unique case (reg_sel)
      REG_MAGIC:   prdata = magic_q;
      REG_MAX_PAY: prdata = max_pay_q;
      default:     prdata = magic_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= MAGIC_RST;
      max_pay_q <= MAX_PAY_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_MAGIC:   magic_q   <= pwdata;
        REG_MAX_PAY: max_pay_q <= pwdata;
        default:     magic_q   <= magic_q;
      endcase
    end
  end

  // handshake
  assign advance     = in_valid_q & (~out_valid_q | res_o.ready);
  assign hdr_i.ready = ~in_valid_q | advance;
  assign in_acc      = hdr_i.valid & hdr_i.ready;
  assign in_valid_d  = in_acc | (in_valid_q & ~advance);

  always_comb begin
    if (advance) begin
      out_valid_d = emit;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // byte check
  always_comb begin
    if (start_q) begin
      pos_d      = '0;
      magic_ok_d = 1'b1;
      zero_d     = 1'b0;
      cmd_ok_d   = 1'b1;
      name_d     = '1;
      size_d     = '0;
    end else begin
      pos_d      = pos_q;
      magic_ok_d = magic_ok_q;
      zero_d     = zero_q;
      cmd_ok_d   = cmd_ok_q;
      name_d     = name_q;
      size_d     = size_q;
    end
    cidx  = 4'(pos_d - CMD_FIRST);
    emit  = 1'b0;
    if (pos_d < HDR_LEN) begin
      emit = (pos_d == LAST_BYTE);
      if (pos_d < CMD_FIRST) begin
        if (magic_q[8*pos_d[1:0] +: 8] != byte_q) begin
          magic_ok_d = 1'b0;
        end
      end else if (pos_d < SIZE_FIRST) begin
        if (zero_d) begin
          if (byte_q != 8'h00) begin
            cmd_ok_d = 1'b0;
          end
        end else if (byte_q == 8'h00) begin
          zero_d = 1'b1;
        end else if (byte_q < PRINT_MIN || byte_q > PRINT_MAX) begin
          cmd_ok_d = 1'b0;
        end
        for (int k = 0; k < NUM_NAMES; k++) begin
          if (cidx <= BLK_LENS[k] && BLK_NAMES[k][cidx] != byte_q) begin
            name_d[k] = 1'b0;
          end
        end
      end else if (pos_d < SIZE_END) begin
        size_d[8*pos_d[1:0] +: 8] = size_d[8*pos_d[1:0] +: 8] | byte_q;
      end
      pos_d = pos_d + 5'd1;
    end
  end

  assign blk_d = |name_d;

  always_comb begin
    if (!magic_ok_d) begin
      err_d = ERR_MAGIC;
    end else if (!cmd_ok_d) begin
      err_d = ERR_CMD;
    end else if ((size_d > max_pay_q && !blk_d) || size_d > SIZE_LIMIT_ABS) begin
      err_d = ERR_SIZE;
    end else begin
      err_d = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      magic_ok_q  <= 1'b1;
      zero_q      <= 1'b0;
      cmd_ok_q    <= 1'b1;
      name_q      <= '1;
      size_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        pos_q      <= pos_d;
        magic_ok_q <= magic_ok_d;
        zero_q     <= zero_d;
        cmd_ok_q   <= cmd_ok_d;
        name_q     <= name_d;
        size_q     <= size_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q  <= hdr_i.hdr_byte;
      start_q <= hdr_i.start_req;
    end
    if (advance && emit) begin
      err_q      <= err_d;
      ok_q       <= (err_d == ERR_NONE);
      blk_q      <= blk_d;
      size_out_q <= size_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.header_ok     = ok_q;
  assign res_o.error_code    = err_q;
  assign res_o.payload_size  = size_out_q;
  assign res_o.is_block_like = blk_q;

endmodule

// File: rtl/p2phc_checker.sv
// ----------------------------------------------------------------------------
// p2phc_checker
// Port-level checks on the verdict channel of the header checker.
// ----------------------------------------------------------------------------
module p2phc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        header_ok_i,
  input logic [1:0]  error_code_i,
  input logic [31:0] payload_size_i,
  input logic        is_block_like_i
);
  import p2phc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(error_code_i)
      && $stable(payload_size_i) && $stable(is_block_like_i))
    else $error("verdict dropped or changed while stalled");

  a_ok_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> header_ok_i == (error_code_i == ERR_NONE))
    else $error("header_ok disagrees with error_code");

  a_ok_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && header_ok_i |-> !payload_size_i[31])
    else $error("header passed with size bit 31 set");

  a_oversize: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_code_i == ERR_SIZE |-> payload_size_i[31] || !is_block_like_i)
    else $error("block-like command flagged oversized below absolute limit");

endmodule

bind p2p_message_header_checker p2phc_checker u_p2phc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .header_ok_i     (res_o.header_ok),
  .error_code_i    (res_o.error_code),
  .payload_size_i  (res_o.payload_size),
  .is_block_like_i (res_o.is_block_like)
);
